### hw/rtl/ncpl_pkg.sv
// ----------------------------------------------------------------------------
// ncpl_pkg: shared types and constants of the nearest centroid pixel labeler
// ----------------------------------------------------------------------------
package ncpl_pkg;

  localparam int MaxCentroidsDef = 16;
  localparam int CoordBitsDef    = 12;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 24;
  localparam logic [CfgIdxBits-1:0] CFG_COUNT   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_X_SCALE = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_Y_SCALE = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // centroid entry width: r,g,b (8.8 each), xy (2 x 8.8), display colour
  localparam int EntryBits = 16 * 3 + 32 + 24;

  // squared distance: five 32-bit squares summed
  localparam int DistBits = 35;

  // controller to datapath commands
  typedef struct packed {
    logic load_px;   // capture pixel features
    logic rd_en;     // read entry at rd_addr
    logic first;     // first entry of a search
    logic acc;       // compare read entry
    logic out_load;  // move best into output register
  } ncpl_cmd_t;

endpackage

### hw/rtl/ncpl_ram.sv
// ----------------------------------------------------------------------------
// ncpl_ram: generic single-port-write, registered-read RAM
// ----------------------------------------------------------------------------
module ncpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### hw/rtl/ncpl_ctrl.sv
// ----------------------------------------------------------------------------
// ncpl_ctrl: sequencer for load and search of the centroid table
// ----------------------------------------------------------------------------
module ncpl_ctrl #(
  parameter int MAX_CENTROIDS = ncpl_pkg::MaxCentroidsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              px_req,   // pixel request accepted
  input  logic [$clog2(MAX_CENTROIDS+1)-1:0] count,
  input  logic                              out_busy, // output register full
  input  logic                              out_take,
  output logic                              ready,
  output logic [(MAX_CENTROIDS>1?$clog2(MAX_CENTROIDS):1)-1:0] rd_addr,
  output ncpl_pkg::ncpl_cmd_t               cmd
);
  import ncpl_pkg::*;

  localparam int AW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int CW = $clog2(MAX_CENTROIDS + 1);
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_LAST = 2'd2, S_WAIT = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // entries issued
  logic        cmp_r, cmp_nxt;      // read data valid this cycle
  logic        first_r, first_nxt;

  assign ready   = (state_r == S_IDLE);
  assign rd_addr = idx_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmp_nxt   = 1'b0;
    first_nxt = first_r;
    cmd       = '0;
    cmd.acc   = cmp_r;
    cmd.first = cmp_r & first_r;
    if (cmp_r) first_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (px_req) begin
          cmd.load_px = 1'b1;
          idx_nxt     = '0;
          first_nxt   = 1'b1;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        cmd.rd_en = 1'b1;
        cmp_nxt   = 1'b1;
        idx_nxt   = idx_r + CW'(1);
        if (idx_r + CW'(1) >= count) state_nxt = S_LAST;
      end
      S_LAST: begin
        // last compare happens this cycle
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!out_busy || out_take) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      cmp_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cmp_r   <= cmp_nxt;
      first_r <= first_nxt;
    end
  end
endmodule

### hw/rtl/ncpl_dpath.sv
// ----------------------------------------------------------------------------
// ncpl_dpath: feature scaling, distance unit and best-entry tracking
// ----------------------------------------------------------------------------
module ncpl_dpath #(
  parameter int MAX_CENTROIDS = ncpl_pkg::MaxCentroidsDef,
  parameter int COORD_BITS    = ncpl_pkg::CoordBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ncpl_pkg::ncpl_cmd_t    cmd,
  input  logic [(MAX_CENTROIDS>1?$clog2(MAX_CENTROIDS):1)-1:0] rd_addr,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  input  logic [11:0]            x_pos,
  input  logic [11:0]            y_pos,
  input  logic [23:0]            x_scale,
  input  logic [23:0]            y_scale,
  input  logic                   wr_en,
  input  logic [3:0]             wr_idx,
  input  logic [ncpl_pkg::EntryBits-1:0] wr_data,
  input  logic                   out_take,
  output logic                   out_valid,
  output logic [3:0]             label,
  output logic [23:0]            out_color
);
  import ncpl_pkg::*;

  localparam int AW  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int CB  = (COORD_BITS < 12) ? COORD_BITS : 12;

  logic [EntryBits-1:0] rdata;
  logic [AW-1:0] waddr;
  logic          we;
  logic [AW-1:0] addr_d_r;

  // load writes only in-range entries
  assign we    = wr_en && ({28'd0, wr_idx} < 32'(MAX_CENTROIDS));
  assign waddr = AW'(wr_idx);

  ncpl_ram #(.WIDTH(EntryBits), .DEPTH(MAX_CENTROIDS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_data),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(rdata)
  );

  // pixel features, position scaled and saturated
  logic [15:0] pr_r, pg_r, pb_r, px_r, py_r;
  logic [CB-1:0] xm, ym;
  logic [35:0] xs, ys;
  assign xm = x_pos[CB-1:0];
  assign ym = y_pos[CB-1:0];
  assign xs = 36'(xm) * 36'(x_scale);
  assign ys = 36'(ym) * 36'(y_scale);

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      pr_r <= {red, 8'd0};
      pg_r <= {green, 8'd0};
      pb_r <= {blue, 8'd0};
      px_r <= (|xs[35:24]) ? 16'hFFFF : xs[23:8];
      py_r <= (|ys[35:24]) ? 16'hFFFF : ys[23:8];
    end
    if (cmd.rd_en) addr_d_r <= rd_addr;
  end

  // entry fields: r g b y x colour, low bits first
  logic [15:0] cr, cg, cbl, cx, cy;
  logic [23:0] ccol;
  assign {ccol, cx, cy, cbl, cg, cr} = rdata;

  function automatic logic [31:0] sqd(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = (a >= b) ? a - b : b - a;
    return 32'(d) * 32'(d);
  endfunction

  logic [DistBits-1:0] cand_dist;
  assign cand_dist = DistBits'(sqd(pr_r, cr)) + DistBits'(sqd(pg_r, cg))
                   + DistBits'(sqd(pb_r, cbl)) + DistBits'(sqd(px_r, cx))
                   + DistBits'(sqd(py_r, cy));

  // best entry so far, strictly smaller replaces
  logic [DistBits-1:0] best_d_r;
  logic [AW-1:0]       best_i_r;
  logic [23:0]         best_c_r;
  always_ff @(posedge clk) begin
    if (cmd.acc && (cmd.first || cand_dist < best_d_r)) begin
      best_d_r <= cand_dist;
      best_i_r <= addr_d_r;
      best_c_r <= ccol;
    end
  end

  // output register
  logic valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (cmd.out_load) valid_r <= 1'b1;
    else if (out_take) valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      label     <= 4'(32'(best_i_r));
      out_color <= best_c_r;
    end
  end
  assign out_valid = valid_r;
endmodule

### hw/rtl/nearest_centroid_pixel_labeler.sv
// ----------------------------------------------------------------------------
// nearest_centroid_pixel_labeler: nearest centroid pixel labeler top level
// ----------------------------------------------------------------------------
// A load request (tuser kind 0) writes one centroid table entry.
// A pixel request (tuser kind 1) reads the first centroid_count entries from
// the table memory, one per cycle through the shared distance unit. The
// input is ready again in the same cycle as the result becomes valid, so a
// new pixel is not taken before the search of the last one has ended. The
// result sits in an output register, and the next pixel may be taken while
// it waits; a search that ends while the previous result is still unread
// stalls until that result is taken.
module nearest_centroid_pixel_labeler #(
  parameter int MAX_CENTROIDS = ncpl_pkg::MaxCentroidsDef,
  parameter int COORD_BITS    = ncpl_pkg::CoordBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index, red, green, blue, x_pos, y_pos, cent_red, cent_green,
  // cent_blue, cent_xy, display_color, then 4 zero bits
  input  logic [159:0] in_tdata,
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // label, out_color, 4 zero bits
  input  logic         cfg_we,
  input  logic [ncpl_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [ncpl_pkg::CfgDataBits-1:0] cfg_data
);
  import ncpl_pkg::*;

  localparam int CW = $clog2(MAX_CENTROIDS + 1);
  localparam int AW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;

  logic [4:0]  count_r;
  logic [23:0] xsc_r, ysc_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 5'd1;
      xsc_r   <= 24'd3276;
      ysc_r   <= 24'd3276;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNT:   count_r <= cfg_data[4:0];
        CFG_X_SCALE: xsc_r   <= cfg_data;
        CFG_Y_SCALE: ysc_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp count to 1..MAX_CENTROIDS
  logic [CW-1:0] count_c;
  always_comb begin
    priority if (count_r == 5'd0) count_c = CW'(1);
    else if (32'(count_r) > 32'(MAX_CENTROIDS)) count_c = CW'(MAX_CENTROIDS);
    else count_c = CW'(count_r);
  end

  logic ready, in_acc, out_take;
  logic [AW-1:0] rd_addr;
  ncpl_cmd_t cmd;

  assign in_tready = ready;
  assign in_acc    = in_tvalid && ready;
  assign out_take  = out_tvalid && out_tready;

  ncpl_ctrl #(.MAX_CENTROIDS(MAX_CENTROIDS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .px_req(in_acc && in_tuser == KIND_PIXEL),
    .count(count_c), .out_busy(out_tvalid), .out_take(out_take),
    .ready(ready), .rd_addr(rd_addr), .cmd(cmd)
  );

  logic [3:0]  label;
  logic [23:0] color;
  ncpl_dpath #(.MAX_CENTROIDS(MAX_CENTROIDS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .rd_addr(rd_addr),
    .red(in_tdata[11:4]), .green(in_tdata[19:12]), .blue(in_tdata[27:20]),
    .x_pos(in_tdata[39:28]), .y_pos(in_tdata[51:40]),
    .x_scale(xsc_r), .y_scale(ysc_r),
    .wr_en(in_acc && in_tuser == KIND_LOAD), .wr_idx(in_tdata[3:0]),
    .wr_data(in_tdata[155:52]),
    .out_take(out_take), .out_valid(out_tvalid), .label(label), .out_color(color)
  );

  assign out_tdata = {4'd0, color, label};

  // a pixel accept starts a search, so ready drops
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == KIND_PIXEL |=> !in_tready)
    else $error("ready held during search");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // compare never coincides with a new pixel capture
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.acc && cmd.load_px))
    else $error("compare during capture");
endmodule

### sim/nearest_centroid_pixel_labeler_tb.sv
// ----------------------------------------------------------------------------
// nearest_centroid_pixel_labeler_tb: self-checking bench for the pixel labeler
// ----------------------------------------------------------------------------
// Loads the centroid table, then streams pixel and load requests through the
// block. Sender and receiver idle at random, and the receiver also holds off
// for a long stretch. Register settings change between phases. Each label and
// colour is checked against a nearest centroid search kept in the bench.
`timescale 1ns / 100ps

module nearest_centroid_pixel_labeler_tb;
  import ncpl_pkg::*;

  localparam int NumEntries = 16;
  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 40;

  // per-phase register settings and idling
  localparam int PhaseCounts[6] = '{16, 0, 31, 7, 1, 16};
  localparam int PhaseXScale[6] = '{3276, 24'hFFFFFF, 0, 65536, 24'h7FFFFF, 1000};
  localparam int PhaseYScale[6] = '{3276, 0, 24'hFFFFFF, 200000, 24'h800000, 777};
  localparam int PhaseIdle[6]   = '{0, 63, 0, 15, 0, 63};
  localparam int PhaseStall[6]  = '{0, 0, 63, 15, 0, 63};

  typedef struct {
    logic        kind;
    logic [3:0]  entry_index;
    logic [7:0]  red, green, blue;
    logic [11:0] x_pos, y_pos;
    logic [15:0] cent_red, cent_green, cent_blue;
    logic [31:0] cent_xy;
    logic [23:0] display_color;
  } px_request_t;

  typedef struct {
    logic [3:0]  label;
    logic [23:0] color;
  } label_result_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [159:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [CfgDataBits-1:0] cfg_data;

  // bench copy of the block state
  logic [15:0] tbl_red [NumEntries], tbl_green [NumEntries], tbl_blue [NumEntries];
  logic [31:0] tbl_xy [NumEntries];
  logic [23:0] tbl_color [NumEntries];
  logic [4:0]  count_reg;
  logic [23:0] xscale_reg, yscale_reg;

  px_request_t   pending_reqs[$];
  px_request_t   cur_req;
  label_result_t expected_labels[$];

  int send_idle_pct, recv_stall_pct;
  int mismatches, labels_seen, loads_sent, cycles;
  int hold_left;
  logic hold_kick;

  nearest_centroid_pixel_labeler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // fields from bit 0 up, zero fill above
  function automatic logic [159:0] pack_request(px_request_t r);
    logic [159:0] d;
    d = '0;
    d[155:0] = {r.display_color, r.cent_xy, r.cent_blue, r.cent_green, r.cent_red,
                r.y_pos, r.x_pos, r.blue, r.green, r.red, r.entry_index};
    return d;
  endfunction

  function automatic logic [15:0] scale_coord(logic [11:0] p, logic [23:0] s);
    logic [63:0] v;
    v = (64'(p) * 64'(s)) >> 8;
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic longint unsigned sq_diff(logic [15:0] a, logic [15:0] b);
    longint unsigned d;
    d = (a >= b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  // nearest centroid search, lowest index on ties
  function automatic label_result_t nearest_label(px_request_t r);
    label_result_t res;
    int n, best;
    longint unsigned cand_dist, best_dist;
    logic [15:0] px, py;
    px = scale_coord(r.x_pos, xscale_reg);
    py = scale_coord(r.y_pos, yscale_reg);
    n = (count_reg == 0) ? 1 : (count_reg > NumEntries ? NumEntries : int'(count_reg));
    best = 0;
    best_dist = 0;
    for (int c = 0; c < n; c++) begin
      cand_dist = sq_diff({r.red, 8'h00}, tbl_red[c])
                + sq_diff({r.green, 8'h00}, tbl_green[c])
                + sq_diff({r.blue, 8'h00}, tbl_blue[c]) + sq_diff(px, tbl_xy[c][31:16])
                + sq_diff(py, tbl_xy[c][15:0]);
      if (c == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best = c;
      end
    end
    res.label = best[3:0];
    res.color = tbl_color[best];
    return res;
  endfunction

  // update table or queue the expected label for an accepted request
  task automatic track_request(px_request_t r);
    if (r.kind == KIND_LOAD) begin
      tbl_red[r.entry_index]   = r.cent_red;
      tbl_green[r.entry_index] = r.cent_green;
      tbl_blue[r.entry_index]  = r.cent_blue;
      tbl_xy[r.entry_index]    = r.cent_xy;
      tbl_color[r.entry_index] = r.display_color;
      loads_sent++;
    end else begin
      expected_labels = {expected_labels, nearest_label(r)};
    end
  endtask

  function automatic px_request_t rand_pixel();
    px_request_t r;
    r.kind = KIND_PIXEL;
    r.entry_index = 4'($urandom);
    r.red = 8'($urandom); r.green = 8'($urandom); r.blue = 8'($urandom);
    r.x_pos = ($urandom_range(9) == 0) ? 12'hFFF : 12'($urandom_range(1023));
    r.y_pos = ($urandom_range(9) == 0) ? 12'hFFF : 12'($urandom);
    r.cent_red = 16'($urandom); r.cent_green = 16'($urandom);
    r.cent_blue = 16'($urandom);
    r.cent_xy = $urandom; r.display_color = 24'($urandom);
    return r;
  endfunction

  // centroids mostly in the pixel range so labels spread over entries
  function automatic px_request_t rand_load(int idx);
    px_request_t r;
    r = rand_pixel();
    r.kind = KIND_LOAD;
    r.entry_index = idx[3:0];
    if ($urandom_range(4) != 0) begin
      r.cent_red   = {8'($urandom), 8'($urandom_range(255))} >> $urandom_range(1);
      r.cent_green = 16'($urandom_range(65535));
      r.cent_blue  = 16'($urandom_range(65535));
      r.cent_xy    = {16'($urandom_range(4095)), 16'($urandom_range(65535))};
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) track_request(cur_req);
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= pack_request(cur_req);
        in_tuser  <= cur_req.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    label_result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        labels_seen++;
        if (expected_labels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_res = expected_labels.pop_front();
          if (out_tdata[3:0] !== exp_res.label || out_tdata[27:4] !== exp_res.color) begin
            mismatches++;
            if (mismatches <= 10)
              $display("label mismatch: exp %0d/%h got %0d/%h", exp_res.label,
                       exp_res.color, out_tdata[3:0], out_tdata[27:4]);
          end
        end
      end
      if (hold_kick) hold_left <= HoldCycles;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      out_tready <= (hold_kick || hold_left > 1) ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[nearest_centroid_pixel_labeler] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COUNT:   count_reg  = val[4:0];
      CFG_X_SCALE: xscale_reg = val;
      CFG_Y_SCALE: yscale_reg = val;
      default: ;
    endcase
  endtask

  // all requests accepted, all labels back, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_labels.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    px_request_t r;

    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_kick = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    mismatches = 0; labels_seen = 0; loads_sent = 0; cycles = 0;
    count_reg = 5'd1; xscale_reg = 24'd3276; yscale_reg = 24'd3276;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fill table, entries 3 and 4 identical for a tie
    for (int i = 0; i < NumEntries; i++) begin
      r = rand_load(i);
      if (i == 0) begin
        r.cent_red = '0; r.cent_green = '0; r.cent_blue = '0; r.cent_xy = '0;
      end else if (i == 15) begin
        r.cent_red = 16'hFFFF; r.cent_green = 16'hFFFF; r.cent_blue = 16'hFFFF;
        r.cent_xy = 32'hFFFF_FFFF; r.display_color = 24'hFFFFFF;
      end else if (i == 4) begin
        r = pending_reqs[3];
        r.entry_index = 4'd4;
      end
      pending_reqs = {pending_reqs, r};
    end
    // default count of one, then all entries
    r = rand_pixel();
    pending_reqs = {pending_reqs, r};
    drain();
    write_reg(CFG_COUNT, CfgDataBits'(16));
    for (int i = 0; i < 8; i++) begin
      r = rand_pixel();
      r.red = (i[0]) ? 8'hFF : 8'h00; r.green = r.red; r.blue = (i[1]) ? 8'hFF : 8'h00;
      r.x_pos = (i[2]) ? 12'hFFF : 12'h000; r.y_pos = r.x_pos;
      if (i == 5) begin
        r.red = tbl_red[3][15:8];
        r.green = tbl_green[3][15:8]; r.blue = tbl_blue[3][15:8];
      end
      pending_reqs = {pending_reqs, r};
    end
    drain();

    // random phases over register settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_COUNT, CfgDataBits'(PhaseCounts[p]));
      write_reg(CFG_X_SCALE, CfgDataBits'(PhaseXScale[p]));
      write_reg(CFG_Y_SCALE, CfgDataBits'(PhaseYScale[p]));
      write_reg(2'd3, CfgDataBits'($urandom));
      send_idle_pct = PhaseIdle[p];
      recv_stall_pct = PhaseStall[p];
      for (int k = 0; k < 105; k++)
        pending_reqs = {pending_reqs, ($urandom_range(99) < 80) ? rand_pixel()
                                      : rand_load(int'($urandom_range(15)))};
      if (p == 4) begin
        @(posedge clk) hold_kick <= 1'b1;
        @(posedge clk) hold_kick <= 1'b0;
      end
      drain();
    end

    $display("%0d labels checked, %0d table loads, counts 0..31, scales 0..max",
             labels_seen, loads_sent);
    if (mismatches == 0 && expected_labels.size() == 0) begin
      $display("[nearest_centroid_pixel_labeler] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[nearest_centroid_pixel_labeler] ERROR");
    end
    $finish;
  end

endmodule
